[hw/rtl/asv_pkg.sv]
package asv_pkg;

	// Oversampling and scan list size
	localparam int SAMPLES  = 5;
	localparam int CHANNELS = 4;

	localparam int SLOTS    = 4;
	localparam int SLOT_W   = 2;
	localparam int CHAN_W   = 5;
	localparam int SMP_W    = 10;
	localparam int AVG_W    = 10;
	localparam int CNT_W    = $clog2(SAMPLES);
	localparam int SUM_W    = $clog2((SAMPLES - 1) * 1023 + 1);

	// Exact divide by SAMPLES-1 for any SUM_W-bit sum:
	// q = (sum * REC_M) >> REC_SH, REC_M = ceil(2^REC_SH / DIV)
	localparam int DIV      = SAMPLES - 1;
	localparam int DIV_SH   = $clog2(DIV);
	localparam int REC_SH   = SUM_W + DIV_SH;
	localparam int REC_W    = REC_SH + 1;
	localparam int PROD_W   = SUM_W + REC_W;
	localparam logic [REC_W-1:0] REC_M = REC_W'(((1 << REC_SH) + DIV - 1) / DIV);

	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(SAMPLES - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CHANNELS - 1);

	// Configuration register indexes
	localparam logic [SLOT_W-1:0] REG_SLOT0 = 2'd0;
	localparam logic [SLOT_W-1:0] REG_SLOT1 = 2'd1;
	localparam logic [SLOT_W-1:0] REG_SLOT2 = 2'd2;
	localparam logic [SLOT_W-1:0] REG_SLOT3 = 2'd3;

	typedef enum logic [1:0] {
		OP_CONV  = 2'd0,
		OP_START = 2'd1,
		OP_READ  = 2'd2
	} op_e;

	typedef logic [SLOTS-1:0][CHAN_W-1:0] chan_tbl_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [SMP_W-1:0]  sample;
		logic [SLOT_W-1:0] read_slot;
	} item_t;

	typedef struct packed {
		logic              average_valid;
		logic [CHAN_W-1:0] average_channel;
		logic [AVG_W-1:0]  average_value;
		logic              scan_complete;
		logic [CHAN_W-1:0] channel_select;
		logic [AVG_W-1:0]  read_value;
	} result_t;

endpackage

[hw/rtl/asv_core.sv]
module asv_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  asv_pkg::item_t    item,
	input  asv_pkg::chan_tbl_t slot_chan,
	output asv_pkg::result_t  result
);

	logic [asv_pkg::CNT_W-1:0]  count_q;
	logic [asv_pkg::SLOT_W-1:0] slot_q;
	logic [asv_pkg::SUM_W-1:0]  sum_q;
	logic                       done_q;
	logic [asv_pkg::SLOTS-1:0][asv_pkg::AVG_W-1:0] store_q;

	logic [asv_pkg::CNT_W-1:0]  count_d;
	logic [asv_pkg::SLOT_W-1:0] slot_d;
	logic [asv_pkg::SUM_W-1:0]  sum_d;
	logic                       done_d;
	logic                       store_we;
	logic [asv_pkg::SUM_W-1:0]  sum_add;
	logic [asv_pkg::PROD_W-1:0] prod;
	logic [asv_pkg::AVG_W-1:0]  avg;
	logic                       last_smp;

	// the first sample of a slot is discarded
	assign sum_add  = (count_q != '0) ? sum_q + asv_pkg::SUM_W'(item.sample) : sum_q;
	assign last_smp = (count_q == asv_pkg::CNT_LAST);
	assign prod     = asv_pkg::PROD_W'(sum_add) * asv_pkg::PROD_W'(asv_pkg::REC_M);
	assign avg      = prod[asv_pkg::REC_SH +: asv_pkg::AVG_W];

	always_comb begin
		count_d  = count_q;
		slot_d   = slot_q;
		sum_d    = sum_q;
		done_d   = done_q;
		store_we = 1'b0;
		result   = '0;
		unique case (item.opcode)
			asv_pkg::OP_CONV: begin
				if (last_smp) begin
					store_we               = 1'b1;
					result.average_valid   = 1'b1;
					result.average_channel = slot_chan[slot_q];
					result.average_value   = avg;
					count_d                = '0;
					sum_d                  = '0;
					if (slot_q == asv_pkg::SLOT_LAST) begin
						slot_d = '0;
						done_d = 1'b1;
					end else begin
						slot_d = slot_q + 1'b1;
					end
				end else begin
					count_d = count_q + 1'b1;
					sum_d   = sum_add;
				end
			end
			asv_pkg::OP_START: begin
				done_d = 1'b0;
			end
			asv_pkg::OP_READ: begin
				result.read_value = store_q[item.read_slot];
			end
			default: begin
			end
		endcase
		result.scan_complete  = done_d;
		result.channel_select = slot_chan[slot_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			slot_q  <= '0;
			sum_q   <= '0;
			done_q  <= 1'b0;
			store_q <= '0;
		end else if (fire) begin
			count_q <= count_d;
			slot_q  <= slot_d;
			sum_q   <= sum_d;
			done_q  <= done_d;
			if (store_we) begin
				store_q[slot_q] <= avg;
			end
		end
	end

endmodule

[hw/rtl/adc_scan_oversample_averager.sv]
// Channel    Signals                               Direction
// request    in_valid/in_ready: opcode, sample,    in
//            read_slot
// result     out_valid/out_ready: average_*,       out
//            scan_complete, channel_select, read_value
// config     cfg_wr_en, cfg_index, cfg_data        in, write only
//
// One request per cycle sustained while out_ready is high; each request sees
// input register -> update logic (accumulate, reciprocal multiply for the
// average) -> result register. Reset clears scan position, partial sum,
// done flag, stored averages and loads slot channels 20..23. A stalled
// result holds in the result register while one more request waits in the
// input register.
module adc_scan_oversample_averager (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic [asv_pkg::SMP_W-1:0]    sample,
	input  logic [asv_pkg::SLOT_W-1:0]   read_slot,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         average_valid,
	output logic [asv_pkg::CHAN_W-1:0]   average_channel,
	output logic [asv_pkg::AVG_W-1:0]    average_value,
	output logic                         scan_complete,
	output logic [asv_pkg::CHAN_W-1:0]   channel_select,
	output logic [asv_pkg::AVG_W-1:0]    read_value,

	input  logic                         cfg_wr_en,
	input  logic [asv_pkg::SLOT_W-1:0]   cfg_index,
	input  logic [asv_pkg::CHAN_W-1:0]   cfg_data
);

	logic               valid_s1;
	asv_pkg::item_t     item_s1;
	logic               valid_s2;
	asv_pkg::result_t   result_s2;
	asv_pkg::result_t   result_d;
	asv_pkg::chan_tbl_t chan_q;
	logic               advance;
	logic               fire;

	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.opcode    <= opcode;
			item_s1.sample    <= sample;
			item_s1.read_slot <= read_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q[asv_pkg::REG_SLOT0] <= 5'd20;
			chan_q[asv_pkg::REG_SLOT1] <= 5'd21;
			chan_q[asv_pkg::REG_SLOT2] <= 5'd22;
			chan_q[asv_pkg::REG_SLOT3] <= 5'd23;
		end else if (cfg_wr_en) begin
			chan_q[cfg_index] <= cfg_data;
		end
	end

	asv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.slot_chan (chan_q),
		.result    (result_d)
	);

	assign out_valid       = valid_s2;
	assign average_valid   = result_s2.average_valid;
	assign average_channel = result_s2.average_channel;
	assign average_value   = result_s2.average_value;
	assign scan_complete   = result_s2.scan_complete;
	assign channel_select  = result_s2.channel_select;
	assign read_value      = result_s2.read_value;

endmodule
